### sv/keypoint_angle_posture_vote_core_macros.svh
// ----------------------------------------------------------------------------
// Posture vote core assertion macros
// Shared property wrappers for the concurrent checks of the posture vote core.
// ----------------------------------------------------------------------------
`ifndef KEYPOINT_ANGLE_POSTURE_VOTE_CORE_MACROS_SVH
`define KEYPOINT_ANGLE_POSTURE_VOTE_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define KAPV_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define KAPV_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/kapv_pkg.sv
// ----------------------------------------------------------------------------
// Posture vote package
// Widths, constants, codes and the arctangent table of the posture vote core.
// ----------------------------------------------------------------------------
`default_nettype none

package kapv_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int DIG_W      = 12;
  localparam int CORD_W_MIN = COORD_BITS + CORDIC_STEPS + 3;
  localparam int NDIG       = (CORD_W_MIN + DIG_W - 1) / DIG_W;
  localparam int CORD_W     = NDIG * DIG_W;
  localparam int DG_W       = $clog2(NDIG);
  localparam int IT_W       = $clog2(CORDIC_STEPS);
  localparam int IDX_W      = $clog2(CORD_W);
  localparam int ABS_W      = $clog2(CORD_W + CORDIC_STEPS + DIG_W) + 1;

  localparam int ZW     = 25;
  localparam int DIFF_W = ZW + 1;
  localparam int ANG_W  = 12;
  localparam int RND_SH = 12;

  localparam logic signed [ZW-1:0]     DEG90     = ZW'(90 * 65536);
  localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(180 * 65536);
  localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(360 * 65536);
  localparam logic signed [DIFF_W-1:0] RND_HALF  = DIFF_W'(2048);

  localparam int ATAN_N = 24;
  localparam int TAB_IW = 5;
  localparam int ATAN_TAB [ATAN_N] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam logic [7:0] NECK_LIMIT_RST  = 8'd120;
  localparam logic [7:0] BACK_LIMIT_RST  = 8'd90;
  localparam logic [3:0] WINDOW_LEN_RST  = 4'd3;
  localparam logic [4:0] WRONG_LIMIT_RST = 5'd2;
  localparam logic [4:0] WRONG_MAX       = 5'd31;

  typedef enum logic [1:0] {
    REG_NECK_LIMIT  = 2'd0,
    REG_BACK_LIMIT  = 2'd1,
    REG_WINDOW_LEN  = 2'd2,
    REG_WRONG_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    STAT_OKAY       = 3'd0,
    STAT_NO_PERSON  = 3'd1,
    STAT_NECK_WRONG = 3'd2,
    STAT_BACK_WRONG = 3'd3,
    STAT_SAMPLING   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DIR_HEAD,
    DIR_HIP,
    DIR_NECK
  } dir_sel_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_DONE
  } cordic_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORD,
    ST_ANGL,
    ST_VOTE
  } top_state_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [IT_W-1:0] i);
    return ZW'(ATAN_TAB[TAB_IW'(i)]);
  endfunction

endpackage

`default_nettype wire

### sv/kapv_cordic.sv
// ----------------------------------------------------------------------------
// Digit-serial CORDIC vectoring unit
// Measures the direction of a vector from +y towards +x; x and y rotate
// through shift registers one digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kapv_cordic (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [kapv_pkg::COORD_BITS:0]   dx,
  input  logic signed [kapv_pkg::COORD_BITS:0]   dy,
  output logic                                   done,
  output logic signed [kapv_pkg::ZW-1:0]         z
);

  kapv_pkg::cordic_state_t state_r, state_nxt;

  logic signed [kapv_pkg::CORD_W-1:0] x_r, y_r;
  logic signed [kapv_pkg::ZW-1:0]     z_r;
  logic [kapv_pkg::IT_W-1:0]          it_r;
  logic [kapv_pkg::DG_W-1:0]          dg_r;
  logic                               neg_r, xsg_r, ysg_r, cx_r, cy_r;

  logic                               load, step;
  logic                               zero_in, first, last_dg, last_it;
  logic                               neg_c, xsg_c, ysg_c, cinx, ciny;
  logic signed [kapv_pkg::COORD_BITS:0] xp, yp;
  logic signed [kapv_pkg::ZW-1:0]     z_ld;
  logic signed [kapv_pkg::CORD_W-1:0] x_ld, y_ld;
  logic [kapv_pkg::DIG_W-1:0]         xsd, ysd;
  logic [kapv_pkg::DIG_W:0]           xsum, ysum;

  function automatic logic [kapv_pkg::DIG_W-1:0] win_dig(
    input logic [kapv_pkg::CORD_W-1:0] v,
    input logic                        sgn,
    input logic [kapv_pkg::IT_W-1:0]   it,
    input logic [kapv_pkg::DG_W-1:0]   dg
  );
    logic [kapv_pkg::DIG_W-1:0] d;
    logic [kapv_pkg::ABS_W-1:0] base;
    logic [kapv_pkg::ABS_W-1:0] a;
    logic [kapv_pkg::IDX_W-1:0] p;
    base = kapv_pkg::ABS_W'(dg) * kapv_pkg::ABS_W'(kapv_pkg::DIG_W)
         + kapv_pkg::ABS_W'(it);
    for (int j = 0; j < kapv_pkg::DIG_W; j++) begin
      a    = base + kapv_pkg::ABS_W'(j);
      p    = kapv_pkg::IDX_W'(it) + kapv_pkg::IDX_W'(j);
      d[j] = (a < kapv_pkg::ABS_W'(kapv_pkg::CORD_W)) ? v[p] : sgn;
    end
    return d;
  endfunction

  assign zero_in = (dx == '0) && (dy == '0);
  assign first   = (dg_r == '0);
  assign last_dg = (dg_r == kapv_pkg::DG_W'(kapv_pkg::NDIG - 1));
  assign last_it = (it_r == kapv_pkg::IT_W'(kapv_pkg::CORDIC_STEPS - 1));

  always_comb begin
    xp   = dy;
    yp   = dx;
    z_ld = '0;
    if (dy < 0) begin
      if (dx >= 0) begin
        xp   = dx;
        yp   = -dy;
        z_ld = kapv_pkg::DEG90;
      end else begin
        xp   = -dx;
        yp   = dy;
        z_ld = -kapv_pkg::DEG90;
      end
    end
    x_ld = kapv_pkg::CORD_W'(xp) <<< kapv_pkg::CORDIC_STEPS;
    y_ld = kapv_pkg::CORD_W'(yp) <<< kapv_pkg::CORDIC_STEPS;
  end

  always_comb begin
    neg_c = first ? y_r[kapv_pkg::CORD_W-1] : neg_r;
    xsg_c = first ? x_r[kapv_pkg::CORD_W-1] : xsg_r;
    ysg_c = first ? y_r[kapv_pkg::CORD_W-1] : ysg_r;
    cinx  = first ? neg_c : cx_r;
    ciny  = first ? !neg_c : cy_r;
    xsd   = win_dig(x_r, xsg_c, it_r, dg_r);
    ysd   = win_dig(y_r, ysg_c, it_r, dg_r);
    xsum  = {1'b0, x_r[kapv_pkg::DIG_W-1:0]} + {1'b0, (neg_c ? ~ysd : ysd)}
          + (kapv_pkg::DIG_W+1)'(cinx);
    ysum  = {1'b0, y_r[kapv_pkg::DIG_W-1:0]} + {1'b0, (neg_c ? xsd : ~xsd)}
          + (kapv_pkg::DIG_W+1)'(ciny);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kapv_pkg::CS_IDLE: begin
        if (start) begin
          state_nxt = zero_in ? kapv_pkg::CS_DONE : kapv_pkg::CS_RUN;
        end
      end
      kapv_pkg::CS_RUN: begin
        if (last_dg && last_it) begin
          state_nxt = kapv_pkg::CS_DONE;
        end
      end
      kapv_pkg::CS_DONE: begin
        state_nxt = kapv_pkg::CS_IDLE;
      end
      default: begin
        state_nxt = kapv_pkg::CS_IDLE;
      end
    endcase
  end

  always_comb begin
    load = (state_r == kapv_pkg::CS_IDLE) && start;
    step = (state_r == kapv_pkg::CS_RUN);
    done = (state_r == kapv_pkg::CS_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kapv_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r  <= x_ld;
      y_r  <= y_ld;
      z_r  <= zero_in ? '0 : z_ld;
      it_r <= '0;
      dg_r <= '0;
    end else if (step) begin
      x_r  <= {xsum[kapv_pkg::DIG_W-1:0], x_r[kapv_pkg::CORD_W-1:kapv_pkg::DIG_W]};
      y_r  <= {ysum[kapv_pkg::DIG_W-1:0], y_r[kapv_pkg::CORD_W-1:kapv_pkg::DIG_W]};
      cx_r <= xsum[kapv_pkg::DIG_W];
      cy_r <= ysum[kapv_pkg::DIG_W];
      if (first) begin
        neg_r <= neg_c;
        xsg_r <= xsg_c;
        ysg_r <= ysg_c;
        z_r   <= neg_c ? (z_r - kapv_pkg::atan_step(it_r))
                       : (z_r + kapv_pkg::atan_step(it_r));
      end
      if (last_dg) begin
        dg_r <= '0;
        it_r <= it_r + 1'b1;
      end else begin
        dg_r <= dg_r + 1'b1;
      end
    end
  end

  assign z = z_r;

endmodule

`default_nettype wire

### sv/kapv_angle.sv
// ----------------------------------------------------------------------------
// Angle between two directions
// Wraps the difference of two directions into half a turn either way and
// rounds its magnitude to a sixteenth of a degree over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module kapv_angle (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [kapv_pkg::ZW-1:0]    a,
  input  logic signed [kapv_pkg::ZW-1:0]    b,
  output logic                              done,
  output logic [kapv_pkg::ANG_W-1:0]        res
);

  logic v1_r, v2_r, v3_r;
  logic signed [kapv_pkg::DIFF_W-1:0] d_r, w_r, w_nxt, mag, rs;
  logic [kapv_pkg::ANG_W-1:0]         res_r;

  always_comb begin
    if (d_r > kapv_pkg::HALF_TURN) begin
      w_nxt = d_r - kapv_pkg::FULL_TURN;
    end else if (d_r < -kapv_pkg::HALF_TURN) begin
      w_nxt = d_r + kapv_pkg::FULL_TURN;
    end else begin
      w_nxt = d_r;
    end
    mag = w_r[kapv_pkg::DIFF_W-1] ? -w_r : w_r;
    rs  = mag + kapv_pkg::RND_HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r   <= kapv_pkg::DIFF_W'(a) - kapv_pkg::DIFF_W'(b);
    w_r   <= w_nxt;
    res_r <= rs[kapv_pkg::RND_SH+kapv_pkg::ANG_W-1:kapv_pkg::RND_SH];
  end

  assign done = v3_r;
  assign res  = res_r;

endmodule

`default_nettype wire

### sv/keypoint_angle_posture_vote_core.sv
// Frames are taken one at a time: in_ready is low from accept until the vote
// result is posted, since the single digit-serial CORDIC unit measures three
// directions in turn. A zero-length direction skips its CORDIC run, and a frame
// with no person skips all three.
// Reset: synchronous, active low; limits return to 120, 90, 3 and 2, both
// counters clear and no result is pending.
// ----------------------------------------------------------------------------
// Keypoint angle posture vote core
// Measures neck and back angles of a pose, checks them against limits and
// votes over a window of frames.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keypoint_angle_posture_vote_core_macros.svh"

module keypoint_angle_posture_vote_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_person_present,
  input  logic [15:0] in_head_x,
  input  logic [15:0] in_head_y,
  input  logic [15:0] in_neck_x,
  input  logic [15:0] in_neck_y,
  input  logic [15:0] in_hip_x,
  input  logic [15:0] in_hip_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [11:0] out_neck_angle,
  output logic [11:0] out_back_angle,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kapv_pkg::top_state_t state_r, state_nxt;
  kapv_pkg::dir_sel_t   sel_r;
  kapv_pkg::status_t    out_status_r, stat_c;
  kapv_pkg::reg_idx_t   ridx;

  logic [7:0] neck_lim_r, back_lim_r;
  logic [3:0] win_len_r, frame_cnt_r;
  logic [4:0] wrong_lim_r, wrong_cnt_r;

  logic                              present_r;
  logic [kapv_pkg::COORD_BITS-1:0]   hx_r, hy_r, nx_r, ny_r, px_r, py_r;
  logic signed [kapv_pkg::ZW-1:0]    z0_r, z1_r, z2_r;
  logic [kapv_pkg::ANG_W-1:0]        neck_r, back_r;
  logic                              ang_back_r, cord_start_r, ang_start_r;
  logic                              out_valid_r;
  logic [kapv_pkg::ANG_W-1:0]        out_neck_r, out_back_r;

  logic                              take, out_free, vote_fire, cfg_wr;
  logic                              cord_go, ang_go, cord_done, ang_done;
  logic signed [kapv_pkg::COORD_BITS:0] cdx, cdy;
  logic signed [kapv_pkg::ZW-1:0]    cord_z, ang_a, ang_b;
  logic [kapv_pkg::ANG_W-1:0]        ang_res;
  logic                              neck_bad, back_bad, win_close;
  logic [4:0]                        wc1, wc2, fc;

  function automatic logic signed [kapv_pkg::COORD_BITS:0] cdiff(
    input logic [kapv_pkg::COORD_BITS-1:0] p,
    input logic [kapv_pkg::COORD_BITS-1:0] q
  );
    return signed'({1'b0, p}) - signed'({1'b0, q});
  endfunction

  function automatic logic [4:0] sat_inc(input logic [4:0] v);
    return (v == kapv_pkg::WRONG_MAX) ? v : v + 5'd1;
  endfunction

  assign cfg_wr = psel && penable && pwrite;
  assign ridx   = kapv_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (ridx)
      kapv_pkg::REG_NECK_LIMIT:  prdata = 32'(neck_lim_r);
      kapv_pkg::REG_BACK_LIMIT:  prdata = 32'(back_lim_r);
      kapv_pkg::REG_WINDOW_LEN:  prdata = 32'(win_len_r);
      kapv_pkg::REG_WRONG_LIMIT: prdata = 32'(wrong_lim_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neck_lim_r  <= kapv_pkg::NECK_LIMIT_RST;
      back_lim_r  <= kapv_pkg::BACK_LIMIT_RST;
      win_len_r   <= kapv_pkg::WINDOW_LEN_RST;
      wrong_lim_r <= kapv_pkg::WRONG_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (ridx)
        kapv_pkg::REG_NECK_LIMIT:  neck_lim_r  <= pwdata[7:0];
        kapv_pkg::REG_BACK_LIMIT:  back_lim_r  <= pwdata[7:0];
        kapv_pkg::REG_WINDOW_LEN:  win_len_r   <= pwdata[3:0];
        kapv_pkg::REG_WRONG_LIMIT: wrong_lim_r <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (sel_r)
      kapv_pkg::DIR_HEAD: begin
        cdx = cdiff(hx_r, nx_r);
        cdy = cdiff(hy_r, ny_r);
      end
      kapv_pkg::DIR_HIP: begin
        cdx = cdiff(px_r, nx_r);
        cdy = cdiff(py_r, ny_r);
      end
      default: begin
        cdx = cdiff(nx_r, px_r);
        cdy = cdiff(ny_r, py_r);
      end
    endcase
    ang_a = ang_back_r ? z2_r : z0_r;
    ang_b = ang_back_r ? kapv_pkg::DEG90 : z1_r;
  end

  kapv_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start_r),
    .dx    (cdx),
    .dy    (cdy),
    .done  (cord_done),
    .z     (cord_z)
  );

  kapv_angle u_angle (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ang_start_r),
    .a     (ang_a),
    .b     (ang_b),
    .done  (ang_done),
    .res   (ang_res)
  );

  always_comb begin
    neck_bad  = neck_r < {neck_lim_r, 4'b0000};
    back_bad  = back_r < {back_lim_r, 4'b0000};
    wc1       = neck_bad ? sat_inc(wrong_cnt_r) : wrong_cnt_r;
    wc2       = back_bad ? sat_inc(wc1) : wc1;
    fc        = {1'b0, frame_cnt_r} + 5'd1;
    win_close = fc >= {1'b0, win_len_r};
    if (!present_r) begin
      stat_c = kapv_pkg::STAT_NO_PERSON;
    end else if (!win_close) begin
      stat_c = kapv_pkg::STAT_SAMPLING;
    end else if (wc2 < wrong_lim_r) begin
      stat_c = kapv_pkg::STAT_OKAY;
    end else if (back_bad) begin
      stat_c = kapv_pkg::STAT_BACK_WRONG;
    end else if (neck_bad) begin
      stat_c = kapv_pkg::STAT_NECK_WRONG;
    end else begin
      stat_c = kapv_pkg::STAT_OKAY;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kapv_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_person_present ? kapv_pkg::ST_CORD : kapv_pkg::ST_VOTE;
        end
      end
      kapv_pkg::ST_CORD: begin
        if (cord_done) begin
          state_nxt = (sel_r == kapv_pkg::DIR_HEAD) ? kapv_pkg::ST_CORD
                                                    : kapv_pkg::ST_ANGL;
        end
      end
      kapv_pkg::ST_ANGL: begin
        if (ang_done) begin
          state_nxt = ang_back_r ? kapv_pkg::ST_VOTE : kapv_pkg::ST_CORD;
        end
      end
      kapv_pkg::ST_VOTE: begin
        if (out_free) begin
          state_nxt = kapv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kapv_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state_r == kapv_pkg::ST_IDLE);
    take      = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;
    cord_go   = (take && in_person_present)
             || ((state_r == kapv_pkg::ST_CORD) && cord_done
                 && (sel_r == kapv_pkg::DIR_HEAD))
             || ((state_r == kapv_pkg::ST_ANGL) && ang_done && !ang_back_r);
    ang_go    = (state_r == kapv_pkg::ST_CORD) && cord_done
             && (sel_r != kapv_pkg::DIR_HEAD);
    vote_fire = (state_r == kapv_pkg::ST_VOTE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kapv_pkg::ST_IDLE;
      cord_start_r <= 1'b0;
      ang_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      wrong_cnt_r  <= '0;
      frame_cnt_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      cord_start_r <= cord_go;
      ang_start_r  <= ang_go;
      if (vote_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (vote_fire && present_r) begin
        if (win_close) begin
          wrong_cnt_r <= '0;
          frame_cnt_r <= '0;
        end else begin
          wrong_cnt_r <= wc2;
          frame_cnt_r <= fc[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      present_r <= in_person_present;
      hx_r      <= kapv_pkg::COORD_BITS'(in_head_x);
      hy_r      <= kapv_pkg::COORD_BITS'(in_head_y);
      nx_r      <= kapv_pkg::COORD_BITS'(in_neck_x);
      ny_r      <= kapv_pkg::COORD_BITS'(in_neck_y);
      px_r      <= kapv_pkg::COORD_BITS'(in_hip_x);
      py_r      <= kapv_pkg::COORD_BITS'(in_hip_y);
      sel_r     <= kapv_pkg::DIR_HEAD;
    end else if ((state_r == kapv_pkg::ST_CORD) && cord_done
                 && (sel_r == kapv_pkg::DIR_HEAD)) begin
      sel_r <= kapv_pkg::DIR_HIP;
    end else if ((state_r == kapv_pkg::ST_ANGL) && ang_done && !ang_back_r) begin
      sel_r <= kapv_pkg::DIR_NECK;
    end
    if (cord_done) begin
      unique case (sel_r)
        kapv_pkg::DIR_HEAD: z0_r <= cord_z;
        kapv_pkg::DIR_HIP:  z1_r <= cord_z;
        default:            z2_r <= cord_z;
      endcase
    end
    if (ang_go) begin
      ang_back_r <= (sel_r == kapv_pkg::DIR_NECK);
    end
    if (ang_done) begin
      if (ang_back_r) begin
        back_r <= ang_res;
      end else begin
        neck_r <= ang_res;
      end
    end
    if (vote_fire) begin
      out_status_r <= stat_c;
      out_neck_r   <= present_r ? neck_r : '0;
      out_back_r   <= present_r ? back_r : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_neck_angle = out_neck_r;
  assign out_back_angle = out_back_r;

  `KAPV_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "Frame taken while busy.")
  `KAPV_ASSERT_IMP(a_cord_done_waited, cord_done, state_r == kapv_pkg::ST_CORD, "Stray CORDIC done.")
  `KAPV_ASSERT_IMP(a_ang_done_waited, ang_done, state_r == kapv_pkg::ST_ANGL, "Stray angle done.")
  `KAPV_ASSERT_NXT(a_vote_lands, vote_fire, out_valid_r && in_ready, "Vote result not posted.")

endmodule

`default_nettype wire

### verif/tb_keypoint_angle_posture_vote_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Posture vote core testbench
// Drives pose frames through the valid/ready input channel and checks every
// result word against a cycle-free predictor of the angle measurement and the
// window vote. The limit registers are rewritten over the APB port between
// phases, covering the register extremes, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_keypoint_angle_posture_vote_core;

  localparam int     CORDIC_ITERS = kapv_pkg::CORDIC_STEPS;
  localparam int     ATAN_LEN     = kapv_pkg::ATAN_N;
  localparam longint DEG_UNITS    = 65536;
  localparam longint HALF_TURN_U  = 180 * DEG_UNITS;
  localparam longint QUARTER_U    = 90 * DEG_UNITS;
  localparam int     STALL_LIMIT  = 12000;
  localparam int     TAIL_CYCLES  = 400;
  localparam int     LONG_HOLD    = 2500;

  typedef struct {
    bit          present;
    logic [15:0] head_x, head_y, neck_x, neck_y, hip_x, hip_y;
  } pose_frame_t;

  typedef struct {
    kapv_pkg::status_t status;
    logic [11:0]       neck;
    logic [11:0]       back;
  } posture_verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_person_present;
  logic [15:0] in_head_x, in_head_y, in_neck_x, in_neck_y, in_hip_x, in_hip_y;
  logic out_valid, out_ready;
  logic [2:0] out_status;
  logic [11:0] out_neck_angle, out_back_angle;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  keypoint_angle_posture_vote_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_person_present(in_person_present),
    .in_head_x(in_head_x), .in_head_y(in_head_y),
    .in_neck_x(in_neck_x), .in_neck_y(in_neck_y),
    .in_hip_x(in_hip_x), .in_hip_y(in_hip_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_neck_angle(out_neck_angle),
    .out_back_angle(out_back_angle),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  longint atan_units [0:ATAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic [7:0] neck_lim  = kapv_pkg::NECK_LIMIT_RST;
  logic [7:0] back_lim  = kapv_pkg::BACK_LIMIT_RST;
  logic [3:0] win_len   = kapv_pkg::WINDOW_LEN_RST;
  logic [4:0] wrong_lim = kapv_pkg::WRONG_LIMIT_RST;
  logic [4:0] wrong_tally = '0;
  logic [3:0] frame_tally = '0;

  posture_verdict_t verdict_q [$];
  int fail_count = 0;
  int frames_sent = 0;
  int absent_sent = 0;
  int results_checked = 0;
  int settings_used = 0;
  int status_seen [8];
  int quiet_cycles = 0;
  int hold_req = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  // Direction of (dx, dy) from +y towards +x in 1/65536 degree.
  function automatic longint heading(input longint dx, input longint dy);
    longint x, y, z, t, xs, ys;
    int i;
    if (dx == 0 && dy == 0) return 0;
    x = dy * (longint'(1) << CORDIC_ITERS);
    y = dx * (longint'(1) << CORDIC_ITERS);
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QUARTER_U;
      end else begin
        t = x; x = -y; y = t; z = -QUARTER_U;
      end
    end
    for (i = 0; i < CORDIC_ITERS && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_units[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_units[i];
      end
    end
    return z;
  endfunction

  function automatic int angle_16th(input longint a, input longint b);
    longint d;
    d = a - b;
    if (d > HALF_TURN_U) d = d - 2 * HALF_TURN_U;
    if (d < -HALF_TURN_U) d = d + 2 * HALF_TURN_U;
    if (d < 0) d = -d;
    return int'((d + 2048) >>> 12);
  endfunction

  function automatic posture_verdict_t judge_frame(input pose_frame_t f);
    posture_verdict_t v;
    longint hx, hy, nx, ny, px, py;
    int neck, back, fc;
    v.status = kapv_pkg::STAT_OKAY;
    v.neck = '0;
    v.back = '0;
    if (!f.present) begin
      v.status = kapv_pkg::STAT_NO_PERSON;
      return v;
    end
    hx = longint'(f.head_x); hy = longint'(f.head_y);
    nx = longint'(f.neck_x); ny = longint'(f.neck_y);
    px = longint'(f.hip_x);  py = longint'(f.hip_y);
    neck = angle_16th(heading(hx - nx, hy - ny), heading(px - nx, py - ny));
    back = angle_16th(heading(nx - px, ny - py), QUARTER_U);
    if (neck < int'(neck_lim) * 16) begin
      v.status = kapv_pkg::STAT_NECK_WRONG;
      wrong_tally = (wrong_tally < kapv_pkg::WRONG_MAX) ? wrong_tally + 5'd1
                                                        : kapv_pkg::WRONG_MAX;
    end
    if (back < int'(back_lim) * 16) begin
      v.status = kapv_pkg::STAT_BACK_WRONG;
      wrong_tally = (wrong_tally < kapv_pkg::WRONG_MAX) ? wrong_tally + 5'd1
                                                        : kapv_pkg::WRONG_MAX;
    end
    fc = int'(frame_tally) + 1;
    if (fc >= int'(win_len)) begin
      if (wrong_tally < wrong_lim) v.status = kapv_pkg::STAT_OKAY;
      wrong_tally = '0;
      frame_tally = '0;
    end else begin
      frame_tally = fc[3:0];
      v.status = kapv_pkg::STAT_SAMPLING;
    end
    v.neck = neck[11:0];
    v.back = back[11:0];
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 200);
  endfunction

  function automatic logic [15:0] to_coord(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic pose_frame_t pose(input bit p,
                                       input logic [15:0] hx, hy, nx, ny, px, py);
    pose_frame_t f;
    f.present = p;
    f.head_x = hx; f.head_y = hy;
    f.neck_x = nx; f.neck_y = ny;
    f.hip_x = px;  f.hip_y = py;
    return f;
  endfunction

  // Mostly plausible poses around a random neck, with full-range noise,
  // absent persons and coincident keypoints mixed in.
  function automatic pose_frame_t random_pose();
    pose_frame_t f;
    int r, s, nx, ny;
    r = $urandom_range(0, 99);
    f = pose(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 16'($urandom));
    if (r < 8) begin
      f.present = 1'b0;
    end else if (r >= 20) begin
      case ($urandom_range(0, 3))
        0: s = 8;
        1: s = 300;
        2: s = 3000;
        default: s = 30000;
      endcase
      nx = $urandom_range(0, 65535);
      ny = $urandom_range(0, 65535);
      f.neck_x = nx[15:0];
      f.neck_y = ny[15:0];
      f.head_x = to_coord(nx + int'($urandom_range(0, 2 * s)) - s);
      f.head_y = to_coord(ny - int'($urandom_range(0, 2 * s)) + s / 4);
      f.hip_x  = to_coord(nx + int'($urandom_range(0, 2 * s)) - s);
      f.hip_y  = to_coord(ny + int'($urandom_range(0, 2 * s)) - s / 4);
      if (r < 25) begin
        if ($urandom_range(0, 1)) begin
          f.head_x = f.neck_x; f.head_y = f.neck_y;
        end else begin
          f.hip_x = f.neck_x; f.hip_y = f.neck_y;
        end
      end
    end
    return f;
  endfunction

  task automatic send_frame(input pose_frame_t f);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_person_present <= f.present;
    in_head_x <= f.head_x; in_head_y <= f.head_y;
    in_neck_x <= f.neck_x; in_neck_y <= f.neck_y;
    in_hip_x <= f.hip_x;   in_hip_y <= f.hip_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdict_q.push_back(judge_frame(f));
    frames_sent++;
    if (!f.present) absent_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() > 0) @(posedge clk);
  endtask

  task automatic cfg_write(input kapv_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      kapv_pkg::REG_NECK_LIMIT:  neck_lim = val[7:0];
      kapv_pkg::REG_BACK_LIMIT:  back_lim = val[7:0];
      kapv_pkg::REG_WINDOW_LEN:  win_len = val[3:0];
      kapv_pkg::REG_WRONG_LIMIT: wrong_lim = val[4:0];
    endcase
  endtask

  // Drains all pending results first, so the block is idle when the limits are written.
  task automatic apply_limits(input logic [7:0] nl, input logic [7:0] bl,
                              input logic [3:0] wl, input logic [4:0] wr);
    drain_results();
    cfg_write(kapv_pkg::REG_NECK_LIMIT, 32'(nl));
    cfg_write(kapv_pkg::REG_BACK_LIMIT, 32'(bl));
    cfg_write(kapv_pkg::REG_WINDOW_LEN, 32'(wl));
    cfg_write(kapv_pkg::REG_WRONG_LIMIT, 32'(wr));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic run_random_frames(input int n);
    repeat (n) send_frame(random_pose());
  endtask

  task automatic test_directed_geometry();
    settings_used++;
    send_frame(pose(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_frame(pose(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_frame(pose(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_frame(pose(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_frame(pose(1'b1, 16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h5000, 16'h7000));
    send_frame(pose(1'b1, 16'h3000, 16'h1000, 16'h4000, 16'h4000, 16'h4000, 16'h4000));
    send_frame(pose(1'b1, 16'h8000, 16'h7000, 16'h8000, 16'h8000, 16'h8000, 16'h9000));
    send_frame(pose(1'b1, 16'h8000, 16'h9000, 16'h8000, 16'h8000, 16'h8000, 16'h7000));
    send_frame(pose(1'b1, 16'h8000, 16'h7000, 16'h8000, 16'h8000, 16'h9000, 16'h8000));
    send_frame(pose(1'b1, 16'h8000, 16'h7000, 16'h8000, 16'h8000, 16'h7000, 16'h8000));
    send_frame(pose(1'b1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_frame(pose(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF));
    send_frame(pose(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000));
    send_frame(pose(1'b1, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
    send_frame(pose(1'b1, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
    send_frame(pose(1'b1, 16'h1235, 16'h2000, 16'h1234, 16'h2000, 16'h1234, 16'h2001));
    send_frame(pose(1'b1, 16'h1233, 16'h1FFF, 16'h1234, 16'h2000, 16'h1233, 16'h2001));
    send_frame(pose(1'b0, 16'h1357, 16'h2468, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0));
    send_frame(pose(1'b1, 16'h2000, 16'h0000, 16'h2000, 16'h1000, 16'h1000, 16'h2000));
  endtask

  task automatic test_register_extremes();
    apply_limits(8'd0, 8'd0, 4'd1, 5'd0);
    run_random_frames(40);
    apply_limits(8'd255, 8'd255, 4'd15, 5'd31);
    run_random_frames(45);
    apply_limits(8'd180, 8'd180, 4'd0, 5'd30);
    run_random_frames(40);
    apply_limits(8'd0, 8'd180, 4'd15, 5'd0);
    run_random_frames(45);
    apply_limits(8'd180, 8'd0, 4'd1, 5'd31);
    run_random_frames(40);
    apply_limits(8'd255, 8'd0, 4'd0, 5'd1);
    run_random_frames(40);
    apply_limits(kapv_pkg::NECK_LIMIT_RST, kapv_pkg::BACK_LIMIT_RST,
                 kapv_pkg::WINDOW_LEN_RST, kapv_pkg::WRONG_LIMIT_RST);
    run_random_frames(40);
  endtask

  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    hold_req = LONG_HOLD;
    run_random_frames(30);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    int phase;
    logic [7:0] nl, bl;
    logic [3:0] wl;
    logic [4:0] wr;
    for (phase = 0; phase < 16; phase++) begin
      nl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180));
      bl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180));
      wl = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      wr = ($urandom_range(0, 9) == 0) ? 5'd31 : 5'($urandom_range(0, 30));
      apply_limits(nl, bl, wl, wr);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      run_random_frames(100);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = rx_idle_on ? pick_gap() : 0;
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    posture_verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      status_seen[out_status]++;
      if (verdict_q.size() == 0) begin
        $error("Result word with nothing expected: status %0d", out_status);
        fail_count++;
      end else begin
        v = verdict_q.pop_front();
        results_checked++;
        if (out_status !== v.status) begin
          $error("status: expected %0d, got %0d", v.status, out_status);
          fail_count++;
        end
        if (out_neck_angle !== v.neck) begin
          $error("neck_angle: expected %0d, got %0d", v.neck, out_neck_angle);
          fail_count++;
        end
        if (out_back_angle !== v.back) begin
          $error("back_angle: expected %0d, got %0d", v.back, out_back_angle);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
               quiet_cycles, verdict_q.size());
      $display("tb_keypoint_angle_posture_vote_core: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_person_present <= 1'b0;
    in_head_x <= '0; in_head_y <= '0;
    in_neck_x <= '0; in_neck_y <= '0;
    in_hip_x <= '0;  in_hip_y <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_geometry();
    test_register_extremes();
    test_output_backpressure();
    test_random_settings();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (verdict_q.size() > 0) begin
      $error("%0d expected result words never arrived", verdict_q.size());
      fail_count++;
    end
    $display("Checked %0d result words for %0d frames (%0d with no person) over %0d settings.",
             results_checked, frames_sent, absent_sent, settings_used);
    $display("Seen: okay %0d, no person %0d, neck wrong %0d, back wrong %0d, sampling %0d.",
             status_seen[kapv_pkg::STAT_OKAY], status_seen[kapv_pkg::STAT_NO_PERSON],
             status_seen[kapv_pkg::STAT_NECK_WRONG], status_seen[kapv_pkg::STAT_BACK_WRONG],
             status_seen[kapv_pkg::STAT_SAMPLING]);
    if (fail_count == 0) begin
      $display("tb_keypoint_angle_posture_vote_core: PASS");
    end else begin
      $display("tb_keypoint_angle_posture_vote_core: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/kapv_pkg.sv
sv/kapv_cordic.sv
sv/kapv_angle.sv
sv/keypoint_angle_posture_vote_core.sv
verif/tb_keypoint_angle_posture_vote_core.sv
